// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the blit writer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RBW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rbw_pkg.sv =====
// ----------------------------------------------------------------------------
// rbw_pkg
// types and constants of the rectangle blit pixel format writer
// ----------------------------------------------------------------------------
`default_nettype none

package rbw_pkg;

	localparam int COORD_W  = 12;
	localparam int SCREEN_W = 13;
	localparam int STRIDE_W = 16;
	localparam int BYTES_W  = 28;
	localparam int SRC_W    = 24;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic [SCREEN_W-1:0] MAX_WIDTH  = 13'd4096;
	localparam logic [SCREEN_W-1:0] MAX_HEIGHT = 13'd4096;

	localparam logic MODE_RECT  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic [1:0] DEPTH_ARGB32 = 2'd0;
	localparam logic [1:0] DEPTH_BGR24  = 2'd1;
	localparam logic [1:0] DEPTH_RGB565 = 2'd2;
	localparam logic [1:0] DEPTH_NONE   = 2'd3;

	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_LINE_STRIDE   = 3'd2;
	localparam logic [2:0] REG_DEPTH_MODE    = 3'd3;
	localparam logic [2:0] REG_SCREEN_BYTES  = 3'd4;
	localparam logic [2:0] REG_OUTPUT_ENABLE = 3'd5;

	localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
	localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE   = 16'd4096;
	localparam logic [BYTES_W-1:0]  RST_SCREEN_BYTES  = 28'd3145728;

	typedef struct packed {
		logic [SCREEN_W-1:0] screen_width;
		logic [SCREEN_W-1:0] screen_height;
		logic [STRIDE_W-1:0] line_stride_bytes;
		logic [1:0]          depth_mode;
		logic [BYTES_W-1:0]  screen_bytes;
		logic                output_enable;
		logic [SCREEN_W-1:0] width_eff;
		logic [SCREEN_W-1:0] height_eff;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] right;
		logic [15:0] bottom;
		logic [31:0] colour;
	} item_t;

	typedef struct packed {
		logic              write_enable;
		logic [BYTES_W-1:0] byte_offset;
		logic [31:0]       write_data;
		logic [1:0]        byte_count_code;
		logic [SRC_W-1:0]  source_index;
		logic              rect_active;
		logic              last;
	} result_t;

	// work handed from the cursor stage to the address and format stages
	typedef struct packed {
		logic               pix;
		logic               src_valid;
		logic               last;
		logic [COORD_W-1:0] cur_line;
		logic [COORD_W-1:0] cur_col;
		logic [COORD_W-1:0] nxt_line;
		logic [COORD_W-1:0] nxt_col;
		logic [31:0]        colour;
	} s1_t;

endpackage

`default_nettype wire

// ===== rtl/rbw_cfg.sv =====
// ----------------------------------------------------------------------------
// rbw_cfg
// apb register file with clamped effective screen size
// ----------------------------------------------------------------------------
`default_nettype none

module rbw_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rbw_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [rbw_pkg::DATA_W-1:0]  pwdata,
	output logic      [rbw_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output rbw_pkg::cfg_t                    cfg
);
	import rbw_pkg::*;

	logic [SCREEN_W-1:0] width_q;
	logic [SCREEN_W-1:0] height_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [1:0]          depth_q;
	logic [BYTES_W-1:0]  sbytes_q;
	logic                enable_q;
	logic [2:0]          idx;
	logic                wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_SCREEN_WIDTH;
			height_q <= RST_SCREEN_HEIGHT;
			stride_q <= RST_LINE_STRIDE;
			depth_q  <= DEPTH_ARGB32;
			sbytes_q <= RST_SCREEN_BYTES;
			enable_q <= 1'b1;
		end else if (wr) begin
			case (idx)
				REG_SCREEN_WIDTH:  width_q  <= pwdata[SCREEN_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[SCREEN_W-1:0];
				REG_LINE_STRIDE:   stride_q <= pwdata[STRIDE_W-1:0];
				REG_DEPTH_MODE:    depth_q  <= pwdata[1:0];
				REG_SCREEN_BYTES:  sbytes_q <= pwdata[BYTES_W-1:0];
				REG_OUTPUT_ENABLE: enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCREEN_WIDTH:  prdata = {19'd0, width_q};
			REG_SCREEN_HEIGHT: prdata = {19'd0, height_q};
			REG_LINE_STRIDE:   prdata = {16'd0, stride_q};
			REG_DEPTH_MODE:    prdata = {30'd0, depth_q};
			REG_SCREEN_BYTES:  prdata = {4'd0, sbytes_q};
			REG_OUTPUT_ENABLE: prdata = {31'd0, enable_q};
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		cfg.screen_width      = width_q;
		cfg.screen_height     = height_q;
		cfg.line_stride_bytes = stride_q;
		cfg.depth_mode        = depth_q;
		cfg.screen_bytes      = sbytes_q;
		cfg.output_enable     = enable_q;
		// screen size is used clamped to 1..max
		if (width_q == '0) begin
			cfg.width_eff = 13'd1;
		end else if (width_q > MAX_WIDTH) begin
			cfg.width_eff = MAX_WIDTH;
		end else begin
			cfg.width_eff = width_q;
		end
		if (height_q == '0) begin
			cfg.height_eff = 13'd1;
		end else if (height_q > MAX_HEIGHT) begin
			cfg.height_eff = MAX_HEIGHT;
		end else begin
			cfg.height_eff = height_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rbw_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbw_ctrl
// rectangle clipping and raster cursor, first pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbw_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rbw_pkg::cfg_t  cfg,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire rbw_pkg::item_t item,
	input  wire logic           s2_free,
	output logic                s1_valid,
	output rbw_pkg::s1_t        s1
);
	import rbw_pkg::*;

	logic               busy_q;
	logic [COORD_W-1:0] cursor_col_q;
	logic [COORD_W-1:0] cursor_line_q;
	logic [COORD_W-1:0] rect_left_q;
	logic [COORD_W-1:0] rect_right_q;
	logic [COORD_W-1:0] rect_bottom_q;
	logic               s1_valid_s1;
	s1_t                s1_s1;

	logic               accept;
	logic [SCREEN_W-1:0] w_m1;
	logic [SCREEN_W-1:0] h_m1;
	logic [COORD_W-1:0] r_clip;
	logic [COORD_W-1:0] b_clip;
	logic               rect_ok;
	logic               at_right;
	logic               at_bottom;
	logic               pix_last;
	logic [COORD_W-1:0] adv_col;
	logic [COORD_W-1:0] adv_line;
	s1_t                s1_d;

	assign item_stall = s1_valid_s1 & ~s2_free;
	assign accept     = item_valid & ~item_stall;

	assign w_m1 = cfg.width_eff - 13'd1;
	assign h_m1 = cfg.height_eff - 13'd1;

	always_comb begin
		r_clip = (item.right >= {3'd0, cfg.width_eff}) ? w_m1[COORD_W-1:0]
			: item.right[COORD_W-1:0];
		b_clip = (item.bottom >= {3'd0, cfg.height_eff}) ? h_m1[COORD_W-1:0]
			: item.bottom[COORD_W-1:0];
		rect_ok = cfg.output_enable
			&& (item.left < {3'd0, cfg.width_eff})
			&& (item.top < {3'd0, cfg.height_eff})
			&& (item.left[COORD_W-1:0] <= r_clip)
			&& (item.top[COORD_W-1:0] <= b_clip);

		at_right  = cursor_col_q >= rect_right_q;
		at_bottom = cursor_line_q >= rect_bottom_q;
		pix_last  = at_right & at_bottom;
		if (at_right) begin
			adv_col  = rect_left_q;
			adv_line = cursor_line_q + 12'd1;
		end else begin
			adv_col  = cursor_col_q + 12'd1;
			adv_line = cursor_line_q;
		end

		s1_d           = '0;
		s1_d.colour    = item.colour;
		s1_d.cur_line  = cursor_line_q;
		s1_d.cur_col   = cursor_col_q;
		if (item.mode == MODE_RECT) begin
			s1_d.src_valid = rect_ok;
			s1_d.nxt_line  = item.top[COORD_W-1:0];
			s1_d.nxt_col   = item.left[COORD_W-1:0];
		end else if (busy_q) begin
			s1_d.pix       = 1'b1;
			s1_d.last      = pix_last;
			s1_d.src_valid = ~pix_last;
			s1_d.nxt_line  = adv_line;
			s1_d.nxt_col   = adv_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			cursor_col_q  <= '0;
			cursor_line_q <= '0;
			rect_left_q   <= '0;
			rect_right_q  <= '0;
			rect_bottom_q <= '0;
		end else if (accept) begin
			if (item.mode == MODE_RECT) begin
				busy_q <= rect_ok;
				if (rect_ok) begin
					rect_left_q   <= item.left[COORD_W-1:0];
					rect_right_q  <= r_clip;
					rect_bottom_q <= b_clip;
					cursor_col_q  <= item.left[COORD_W-1:0];
					cursor_line_q <= item.top[COORD_W-1:0];
				end
			end else if (busy_q) begin
				if (pix_last) begin
					busy_q <= 1'b0;
				end else begin
					cursor_col_q  <= adv_col;
					cursor_line_q <= adv_line;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s2_free) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	assign s1_valid = s1_valid_s1;
	assign s1       = s1_s1;

	// the rectangle only ends on a transaction
	`RBW_ASSERT_IMPL(a_busy_drop, clk, arst_n, $fell(busy_q), $past(accept),
		"busy cleared without an accepted transaction")
	`RBW_ASSERT_NEXT(a_busy_keep, clk, arst_n,
		accept && item.mode == MODE_PIXEL && busy_q && !pix_last, busy_q,
		"rectangle dropped before its last pixel")

endmodule

`default_nettype wire

// ===== rtl/rbw_datapath.sv =====
// ----------------------------------------------------------------------------
// rbw_datapath
// address multiply stage, bound check, pixel conversion and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbw_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rbw_pkg::cfg_t cfg,
	input  wire logic          s1_valid,
	input  wire rbw_pkg::s1_t  s1,
	output logic               s2_free,
	output logic               result_valid,
	input  wire logic          result_stall,
	output rbw_pkg::result_t   result
);
	import rbw_pkg::*;

	logic               s2_valid_s2;
	logic [BYTES_W-1:0] line_off_s2;
	logic [13:0]        col_off_s2;
	logic [24:0]        src_base_s2;
	logic [COORD_W-1:0] nxt_col_s2;
	logic               pix_s2;
	logic               src_valid_s2;
	logic               last_s2;
	logic [31:0]        colour_s2;

	logic               result_valid_q;
	result_t            result_q;

	logic               out_free;
	logic [2:0]         pix_bytes;
	logic [13:0]        col_off;
	logic [28:0]        off;
	logic [28:0]        off_end;
	logic [24:0]        src_sum;
	logic               wr_ok;
	logic [7:0]         rr;
	logic [7:0]         gg;
	logic [7:0]         bb;
	logic [31:0]        data;
	result_t            result_d;

	assign out_free = ~result_valid_q | ~result_stall;
	assign s2_free  = ~s2_valid_s2 | out_free;

	always_comb begin
		case (cfg.depth_mode)
			DEPTH_ARGB32: begin
				pix_bytes = 3'd4;
				col_off   = {s1.cur_col, 2'b00};
			end
			DEPTH_BGR24: begin
				pix_bytes = 3'd3;
				col_off   = {1'b0, s1.cur_col, 1'b0} + {2'b00, s1.cur_col};
			end
			DEPTH_RGB565: begin
				pix_bytes = 3'd2;
				col_off   = {1'b0, s1.cur_col, 1'b0};
			end
			default: begin
				pix_bytes = 3'd0;
				col_off   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			s2_valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			line_off_s2  <= {16'd0, s1.cur_line} * {12'd0, cfg.line_stride_bytes};
			col_off_s2   <= col_off;
			src_base_s2  <= {13'd0, s1.nxt_line} * {12'd0, cfg.width_eff};
			nxt_col_s2   <= s1.nxt_col;
			pix_s2       <= s1.pix;
			src_valid_s2 <= s1.src_valid;
			last_s2      <= s1.last;
			colour_s2    <= s1.colour;
		end
	end

	always_comb begin
		rr      = colour_s2[23:16];
		gg      = colour_s2[15:8];
		bb      = colour_s2[7:0];
		off     = {1'b0, line_off_s2} + {15'd0, col_off_s2};
		off_end = off + {26'd0, pix_bytes};
		// skip the write once the pixel would reach the end of the screen
		wr_ok   = pix_s2 && (cfg.depth_mode != DEPTH_NONE)
			&& (off_end < {1'b0, cfg.screen_bytes});
		src_sum = src_base_s2 + {13'd0, nxt_col_s2};
		case (cfg.depth_mode)
			DEPTH_ARGB32: data = {8'hFF, rr, gg, bb};
			DEPTH_BGR24:  data = {8'h00, rr, gg, bb};
			DEPTH_RGB565: data = {16'd0, rr & 8'hF8, 3'b000, 5'd0}
				| {16'd0, 5'd0, gg & 8'hFC, 3'b000}
				| {27'd0, bb[7:3]};
			default:      data = '0;
		endcase

		result_d                 = '0;
		result_d.write_enable    = wr_ok;
		result_d.byte_offset     = wr_ok ? off[BYTES_W-1:0] : '0;
		result_d.write_data      = wr_ok ? data : '0;
		result_d.byte_count_code = wr_ok ? cfg.depth_mode : DEPTH_ARGB32;
		result_d.source_index    = src_valid_s2 ? src_sum[SRC_W-1:0] : '0;
		result_d.rect_active     = src_valid_s2;
		result_d.last            = last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s2_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`RBW_ASSERT_IMPL(a_we_depth, clk, arst_n, result_valid_q && result_q.write_enable,
		result_q.byte_count_code != DEPTH_NONE, "write issued in the no-write depth")
	`RBW_ASSERT_IMPL(a_last_idle, clk, arst_n, result_valid_q && result_q.last,
		!result_q.rect_active && result_q.source_index == '0,
		"final pixel still reports an active rectangle")

endmodule

`default_nettype wire

// ===== rtl/rect_blit_pixel_format_writer.sv =====
// ----------------------------------------------------------------------------
// rect_blit_pixel_format_writer
// top level of the rectangle blit writer
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while item_stall is low and returns
// exactly one result per transaction, in order. A rectangle transaction is
// clipped and arms the raster cursor in the accept cycle, so pixels may follow
// in the very next cycle. The pipeline has three registers: the cursor stage,
// the stage that holds the line times stride and line times width products,
// and the result register that holds the bound check and the converted pixel.
// A stall on the result side backs up through these stages; the input side
// stalls only when all of them are full and the result side stalls. The user
// must write the configuration registers over the apb port only while no
// transaction is in flight; the block itself does not enforce this.
`default_nettype none

module rect_blit_pixel_format_writer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rbw_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [rbw_pkg::DATA_W-1:0]  pwdata,
	output logic      [rbw_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire rbw_pkg::item_t              item,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output rbw_pkg::result_t                 result
);
	import rbw_pkg::*;

	cfg_t cfg;
	logic s1_valid;
	s1_t  s1;
	logic s2_free;

	rbw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.s2_free    (s2_free),
		.s1_valid   (s1_valid),
		.s1         (s1)
	);

	rbw_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s1_valid     (s1_valid),
		.s1           (s1),
		.s2_free      (s2_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
